[design/assert_macros.svh]
// Assertion macros used by the top level of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("forbidden condition seen");

`endif

[design/dte_pkg.sv]
// Types, codes and constants of the DER TLV encoder.
package dte_pkg;

	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int GROUP_W = 7;
	localparam int CNT_W   = 3;
	localparam int TAG_W   = 5;

	// Number of bytes or groups held in the shift word.
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(4);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	localparam logic [TAG_W-1:0] TAG_BOOLEAN  = TAG_W'(1);
	localparam logic [TAG_W-1:0] TAG_INTEGER  = TAG_W'(2);
	localparam logic [TAG_W-1:0] TAG_BITSTR   = TAG_W'(3);
	localparam logic [TAG_W-1:0] TAG_SEQUENCE = TAG_W'(16);
	localparam logic [TAG_W-1:0] TAG_SET      = TAG_W'(17);

	localparam logic [BYTE_W-1:0] CONSTRUCTED_BIT = 8'h20;
	localparam logic [BYTE_W-1:0] LEN_LONG_FORM   = 8'h80;
	localparam logic [BYTE_W-1:0] BOOL_TRUE       = 8'hFF;
	localparam logic [BYTE_W-1:0] MAX_UNUSED_BITS = 8'h07;

	typedef enum logic [1:0] {
		CMD_HEADER  = 2'd0,
		CMD_CONTENT = 2'd1,
		CMD_ARC     = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_BITSTR = 2'd1,
		ERR_SIGN   = 2'd2,
		ERR_LENGTH = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN,
		S_TAG,
		S_LHEAD,
		S_LBODY,
		S_EXTRA,
		S_ARC,
		S_ONE
	} state_t;

	// Control of the shared shift unit.
	typedef struct packed {
		logic load;
		logic shift;
		logic group_mode;
	} shift_ctl_t;

	// One output word handed from the sequencer to the output register.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
		err_t              err;
	} emit_t;

endpackage

[design/dte_in_if.sv]
// Input channel of the DER TLV encoder: one command word per handshake.
interface dte_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [4:0]  tag_id;
	logic [31:0] content_length;
	logic [7:0]  first_value_byte;
	logic        is_positive;
	logic [7:0]  unused_bit_count;
	logic        bool_value;
	logic [7:0]  data_byte;
	logic [27:0] arc_value;

	modport source (
		output valid, cmd, tag_id, content_length, first_value_byte,
		       is_positive, unused_bit_count, bool_value, data_byte, arc_value,
		input  ready
	);

	modport sink (
		input  valid, cmd, tag_id, content_length, first_value_byte,
		       is_positive, unused_bit_count, bool_value, data_byte, arc_value,
		output ready
	);
endinterface

[design/dte_out_if.sv]
// Output channel of the DER TLV encoder: one encoded byte per handshake.
interface dte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] error_code;

	modport source (
		output valid, out_byte, last, error_code,
		input  ready
	);

	modport sink (
		input  valid, out_byte, last, error_code,
		output ready
	);
endinterface

[design/der_tlv_encoder.sv]
// Top level of the DER TLV encoder: sequencer, shift unit and output register.
// The encoder takes one command word at a time and is not ready until its last
// byte has entered the output register; that register lets the next word be
// taken while the final byte still waits downstream. A content-byte word and an
// error result each emit one byte; a word with the reserved command emits none.
// A header word emits B bytes (2 to 7: tag, length, up to four long-form length
// bytes, extra byte). For a long-form length with N length bytes (1 to 4) the
// shared shift word first drops leading zero length bytes in S_ALIGN; a
// short-form length skips that step. An OID arc word is aligned in S_ALIGN the
// same way and then emits G base-128 groups (1 to 4). A byte waits while the
// output register is full and not draining.
`include "assert_macros.svh"

module der_tlv_encoder
	import dte_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	dte_in_if.sink  item,
	dte_out_if.source result
);

	shift_ctl_t         sctl;
	emit_t              emit;
	logic               emit_ok;
	logic [WORD_W-1:0]  load_word;
	logic [BYTE_W-1:0]  top_byte;
	logic [GROUP_W-1:0] top_group;
	logic [BYTE_W-1:0]  low_byte;
	logic               top_zero;

	logic               ovalid_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               olast_q;
	err_t               oerr_q;

	dte_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.emit_ok   (emit_ok),
		.emit      (emit),
		.sctl      (sctl),
		.load_word (load_word),
		.top_byte  (top_byte),
		.top_group (top_group),
		.low_byte  (low_byte),
		.top_zero  (top_zero)
	);

	dte_shift_unit u_shift (
		.clk       (clk),
		.ctl       (sctl),
		.load_word (load_word),
		.top_byte  (top_byte),
		.top_group (top_group),
		.low_byte  (low_byte),
		.top_zero  (top_zero)
	);

	// Emit a new byte when the output register is empty or draining
	assign emit_ok = !ovalid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit.valid) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			obyte_q <= emit.data;
			olast_q <= emit.last;
			oerr_q  <= emit.err;
		end
	end

	assign result.valid      = ovalid_q;
	assign result.out_byte   = obyte_q;
	assign result.last       = olast_q;
	assign result.error_code = oerr_q;

	// A real command keeps the input closed in the next cycle
	`ASSERT_AT(a_busy_after_accept, clk, arst_n,
		(item.valid && item.ready && (item.cmd != CMD_RSVD)) |=> !item.ready)
	// No byte is produced while the input is open
	`ASSERT_NEVER(a_no_emit_when_idle, clk, arst_n, item.ready && emit.valid)
	// An error result is a single zero byte marked last
	`ASSERT_AT(a_error_shape, clk, arst_n,
		(ovalid_q && (oerr_q != ERR_OK)) |-> (olast_q && (obyte_q == '0)))

endmodule

[design/dte_shift_unit.sv]
// Shared shift word: length bytes and OID groups leave it from the top.
module dte_shift_unit
	import dte_pkg::*;
(
	input  logic              clk,
	input  shift_ctl_t        ctl,
	input  logic [WORD_W-1:0] load_word,
	output logic [BYTE_W-1:0] top_byte,
	output logic [GROUP_W-1:0] top_group,
	output logic [BYTE_W-1:0] low_byte,
	output logic              top_zero
);

	logic [WORD_W-1:0] word_q;

	// Load a new word or advance by one byte or one group
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.shift) begin
			if (ctl.group_mode) begin
				word_q <= word_q << GROUP_W;
			end else begin
				word_q <= word_q << BYTE_W;
			end
		end
	end

	// Present the leading field and its zero flag
	assign top_byte  = word_q[WORD_W-1 -: BYTE_W];
	assign top_group = word_q[WORD_W-1 -: GROUP_W];
	assign low_byte  = word_q[BYTE_W-1:0];
	assign top_zero  = ctl.group_mode ? (top_group == '0) : (top_byte == '0);

endmodule

[design/dte_sequencer.sv]
// Command decode and byte sequencer of the DER TLV encoder.
module dte_sequencer
	import dte_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	dte_in_if.sink             item,
	input  logic               emit_ok,
	output emit_t              emit,
	output shift_ctl_t         sctl,
	output logic [WORD_W-1:0]  load_word,
	input  logic [BYTE_W-1:0]  top_byte,
	input  logic [GROUP_W-1:0] top_group,
	input  logic [BYTE_W-1:0]  low_byte,
	input  logic               top_zero
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              is_arc_q, is_arc_d;
	logic              long_q, long_d;
	logic              has_extra_q, has_extra_d;
	logic [BYTE_W-1:0] extra_q, extra_d;
	logic [BYTE_W-1:0] tag_byte_q, tag_byte_d;
	logic [BYTE_W-1:0] one_byte_q, one_byte_d;
	err_t              one_err_q, one_err_d;

	logic              accept;
	logic              is_int, is_bit, is_bool, is_cons;
	logic              pad, add_one;
	logic [WORD_W:0]   vlen_wide;
	logic [WORD_W-1:0] vlen;
	logic              vlen_long;
	err_t              hdr_err;
	logic [BYTE_W-1:0] hdr_extra;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// Decode the header word: encoded length, extra byte and error
	always_comb begin
		is_int  = (item.tag_id == TAG_INTEGER);
		is_bit  = (item.tag_id == TAG_BITSTR);
		is_bool = (item.tag_id == TAG_BOOLEAN);
		is_cons = (item.tag_id == TAG_SEQUENCE) || (item.tag_id == TAG_SET);
		pad     = is_int && item.is_positive && item.first_value_byte[BYTE_W-1];
		add_one = pad || is_bit;
		vlen_wide = {1'b0, item.content_length} + {{WORD_W{1'b0}}, add_one};
		vlen      = is_bool ? WORD_W'(1) : vlen_wide[WORD_W-1:0];
		vlen_long = (vlen[WORD_W-1:GROUP_W] != '0);
		if (is_int && !item.is_positive && !item.first_value_byte[BYTE_W-1]) begin
			hdr_err = ERR_SIGN;
		end else if (vlen_wide[WORD_W]) begin
			hdr_err = ERR_LENGTH;
		end else if (is_bit && ((item.unused_bit_count > MAX_UNUSED_BITS) ||
		                        (item.content_length == '0))) begin
			hdr_err = ERR_BITSTR;
		end else begin
			hdr_err = ERR_OK;
		end
		if (is_bool) begin
			hdr_extra = item.bool_value ? BOOL_TRUE : '0;
		end else if (is_bit) begin
			hdr_extra = item.unused_bit_count;
		end else begin
			hdr_extra = '0;
		end
	end

	// Hold state and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Hold the decoded header fields
	always_ff @(posedge clk) begin
		is_arc_q    <= is_arc_d;
		long_q      <= long_d;
		has_extra_q <= has_extra_d;
		extra_q     <= extra_d;
		tag_byte_q  <= tag_byte_d;
		one_byte_q  <= one_byte_d;
		one_err_q   <= one_err_d;
	end

	// Next state, shift control and emitted word
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		is_arc_d    = is_arc_q;
		long_d      = long_q;
		has_extra_d = has_extra_q;
		extra_d     = extra_q;
		tag_byte_d  = tag_byte_q;
		one_byte_d  = one_byte_q;
		one_err_d   = one_err_q;
		sctl.load       = 1'b0;
		sctl.shift      = 1'b0;
		sctl.group_mode = is_arc_q;
		load_word   = {item.arc_value, {(WORD_W-28){1'b0}}};
		emit.valid  = 1'b0;
		emit.data   = '0;
		emit.last   = 1'b0;
		emit.err    = ERR_OK;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_HEADER: begin
							if (hdr_err != ERR_OK) begin
								one_byte_d = '0;
								one_err_d  = hdr_err;
								state_d    = S_ONE;
							end else begin
								is_arc_d    = 1'b0;
								long_d      = vlen_long;
								has_extra_d = add_one || is_bool;
								extra_d     = hdr_extra;
								tag_byte_d  = {{(BYTE_W-TAG_W){1'b0}}, item.tag_id} |
								              (is_cons ? CONSTRUCTED_BIT : '0);
								sctl.load   = 1'b1;
								load_word   = vlen;
								cnt_d       = CNT_FULL;
								state_d     = vlen_long ? S_ALIGN : S_TAG;
							end
						end
						CMD_CONTENT: begin
							one_byte_d = item.data_byte;
							one_err_d  = ERR_OK;
							state_d    = S_ONE;
						end
						CMD_ARC: begin
							is_arc_d  = 1'b1;
							sctl.load = 1'b1;
							cnt_d     = CNT_FULL;
							state_d   = S_ALIGN;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ALIGN: begin
				// Drop leading zero bytes or groups, keep at least one
				if ((cnt_q > CNT_ONE) && top_zero) begin
					sctl.shift = 1'b1;
					cnt_d      = cnt_q - CNT_ONE;
				end else begin
					state_d = is_arc_q ? S_ARC : S_TAG;
				end
			end
			S_TAG: begin
				if (emit_ok) begin
					emit.valid = 1'b1;
					emit.data  = tag_byte_q;
					state_d    = S_LHEAD;
				end
			end
			S_LHEAD: begin
				if (emit_ok) begin
					emit.valid = 1'b1;
					if (long_q) begin
						emit.data = LEN_LONG_FORM | {{(BYTE_W-CNT_W){1'b0}}, cnt_q};
						state_d   = S_LBODY;
					end else begin
						emit.data = low_byte;
						emit.last = !has_extra_q;
						state_d   = has_extra_q ? S_EXTRA : S_IDLE;
					end
				end
			end
			S_LBODY: begin
				if (emit_ok) begin
					emit.valid = 1'b1;
					emit.data  = top_byte;
					sctl.shift = 1'b1;
					cnt_d      = cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) begin
						emit.last = !has_extra_q;
						state_d   = has_extra_q ? S_EXTRA : S_IDLE;
					end
				end
			end
			S_EXTRA: begin
				if (emit_ok) begin
					emit.valid = 1'b1;
					emit.data  = extra_q;
					emit.last  = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_ARC: begin
				// Continuation bit on every group but the final one
				if (emit_ok) begin
					emit.valid = 1'b1;
					emit.data  = {(cnt_q != CNT_ONE), top_group};
					emit.last  = (cnt_q == CNT_ONE);
					sctl.shift = 1'b1;
					cnt_d      = cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) begin
						state_d = S_IDLE;
					end
				end
			end
			S_ONE: begin
				if (emit_ok) begin
					emit.valid = 1'b1;
					emit.data  = one_byte_q;
					emit.last  = 1'b1;
					emit.err   = one_err_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
